// ===== design/sou_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sou_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned HDR_LAST   = 11;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ERR   = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ELEMENT_COUNT  = 2'd0,
    REG_ELEMENT_BYTES  = 2'd1,
    REG_FILL_DEFINED   = 2'd2,
    REG_REQUESTED_BITS = 2'd3
  } reg_idx_t;

  // One queue entry. The data field carries the minimum for a start entry
  // and the stream byte in its low eight bits for a data entry.
  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] data;
    logic [5:0]  nbits;
    logic        last_byte;
  } entry_t;

  // Element width in bits, with out-of-range byte counts clamped to 1..8.
  function automatic logic [6:0] elem_width(input logic [3:0] eb);
    logic [3:0] c;
    begin
      c = eb;
      if (eb == 4'd0) c = 4'd1;
      if (eb > 4'd8) c = 4'd8;
      elem_width = {c, 3'b000};
    end
  endfunction

  function automatic logic [63:0] width_mask(input logic [3:0] eb);
    logic [6:0] w;
    begin
      w = elem_width(eb);
      width_mask = ~64'd0 >> (7'd64 - w);
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/scale_offset_unpacker.sv =====
// Channel   Direction  Handshake                Payload
// in_       request    in_valid / in_ready      in_byte, in_chunk_end
// out_      result     out_valid / out_ready    out_elem_value, out_last_element,
//                                               out_bad_header
// cfg_      write      cfg_we                   cfg_index, cfg_data
//
// One request is taken per cycle while the queue between the header parser and
// the element extractor has room. The extractor emits each element that a byte
// completes in turn, and stores any bits left over for the next element before
// it lets the byte go from the queue.
// Reset is synchronous and active low; configuration returns to its defaults.
// A stalled result register holds the extractor, which fills the queue and then
// drops in_ready; header bytes that make no queue entry still need queue room.
`timescale 1ns / 1ps
`default_nettype none
module scale_offset_unpacker #(
  parameter int unsigned FIFO_DEPTH = sou_pkg::FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_chunk_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_elem_value,
  output logic             out_last_element,
  output logic             out_bad_header,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0]     element_count_r;
  logic [3:0]      element_bytes_r;
  logic            fill_defined_r;
  logic [6:0]      requested_bits_r;

  logic            q_push, q_pop, q_full, q_valid;
  sou_pkg::entry_t q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_count_r  <= 32'd1;
      element_bytes_r  <= 4'd4;
      fill_defined_r   <= 1'b0;
      requested_bits_r <= 7'd0;
    end else if (cfg_we) begin
      unique case (sou_pkg::reg_idx_t'(cfg_index))
        sou_pkg::REG_ELEMENT_COUNT:  element_count_r  <= cfg_data;
        sou_pkg::REG_ELEMENT_BYTES:  element_bytes_r  <= cfg_data[3:0];
        sou_pkg::REG_FILL_DEFINED:   fill_defined_r   <= cfg_data[0];
        sou_pkg::REG_REQUESTED_BITS: requested_bits_r <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  sou_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .in_chunk_end       (in_chunk_end),
    .cfg_element_bytes  (element_bytes_r),
    .cfg_requested_bits (requested_bits_r),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_entry            (q_in)
  );

  sou_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  sou_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_entry           (q_head),
    .q_pop             (q_pop),
    .cfg_element_count (element_count_r),
    .cfg_element_bytes (element_bytes_r),
    .cfg_fill_defined  (fill_defined_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_elem_value    (out_elem_value),
    .out_last_element  (out_last_element),
    .out_bad_header    (out_bad_header)
  );

`ifndef SYNTHESIS
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_header) |-> (out_elem_value == 64'd0 && out_last_element))
    else $error("error result carries a value or lacks the last flag");

  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bad_header) |->
      ((out_elem_value & ~sou_pkg::width_mask(element_bytes_r)) == 64'd0))
    else $error("element value has bits above the element width");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

// ===== design/sou_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sou_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_chunk_end,
  input  wire logic [3:0]     cfg_element_bytes,
  input  wire logic [6:0]     cfg_requested_bits,
  input  wire logic           q_full,
  output logic                q_push,
  output sou_pkg::entry_t     q_entry
);

  typedef enum logic [2:0] {
    FS_HDR  = 3'b001,
    FS_BODY = 3'b010,
    FS_SKIP = 3'b100
  } fstate_t;

  fstate_t     state_r, state_nxt;
  logic [3:0]  hpos_r, hpos_nxt;
  logic [31:0] pbits_r, pbits_nxt;
  logic [63:0] offs_r, offs_nxt;
  logic        acc;
  logic [6:0]  w;
  logic        bad;
  logic [2:0]  lane;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign w        = sou_pkg::elem_width(cfg_element_bytes);
  assign bad      = (pbits_r == 32'd0) || (pbits_r >= {25'd0, w}) ||
                    (cfg_requested_bits > w);
  assign lane     = 3'(hpos_r - 4'd4);

  always_comb begin
    state_nxt         = state_r;
    hpos_nxt          = hpos_r;
    pbits_nxt         = pbits_r;
    offs_nxt          = offs_r;
    q_push            = 1'b0;
    q_entry.cmd       = sou_pkg::CMD_DATA;
    q_entry.data      = {56'd0, in_byte};
    q_entry.nbits     = pbits_r[5:0];
    q_entry.last_byte = in_chunk_end;
    if (acc) begin
      unique case (state_r)
        FS_HDR: begin
          if (hpos_r < 4'd4) begin
            if (hpos_r == 4'd0) begin
              pbits_nxt = {24'd0, in_byte};
              offs_nxt  = 64'd0;
            end else begin
              pbits_nxt = pbits_r | ({24'd0, in_byte} << {hpos_r[1:0], 3'b000});
            end
          end else begin
            offs_nxt = offs_r | ({56'd0, in_byte} << {lane, 3'b000});
          end
          hpos_nxt = hpos_r + 4'd1;
          if (hpos_r == 4'(sou_pkg::HDR_LAST)) begin
            hpos_nxt     = 4'd0;
            q_push       = 1'b1;
            q_entry.data = {in_byte, offs_r[55:0]};
            if (bad) begin
              q_entry.cmd = sou_pkg::CMD_ERR;
              state_nxt   = FS_SKIP;
            end else begin
              q_entry.cmd = sou_pkg::CMD_START;
              state_nxt   = FS_BODY;
            end
          end
        end
        FS_BODY: begin
          q_push = 1'b1;
        end
        FS_SKIP: begin
          q_push = 1'b0;
        end
        default: begin
          state_nxt = FS_HDR;
        end
      endcase
      if (in_chunk_end) begin
        state_nxt = FS_HDR;
        hpos_nxt  = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_HDR;
      hpos_r  <= 4'd0;
      pbits_r <= 32'd0;
      offs_r  <= 64'd0;
    end else begin
      state_r <= state_nxt;
      hpos_r  <= hpos_nxt;
      pbits_r <= pbits_nxt;
      offs_r  <= offs_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/sou_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sou_fifo #(
  parameter int unsigned DEPTH = sou_pkg::FIFO_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire sou_pkg::entry_t push_entry,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output sou_pkg::entry_t      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sou_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_entry;
  end

endmodule
`default_nettype wire

// ===== design/sou_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sou_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire sou_pkg::entry_t q_entry,
  output logic                 q_pop,
  input  wire logic [31:0]     cfg_element_count,
  input  wire logic [3:0]      cfg_element_bytes,
  input  wire logic            cfg_fill_defined,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [63:0]          out_elem_value,
  output logic                 out_last_element,
  output logic                 out_bad_header
);

  logic        active_r, active_nxt;
  logic [5:0]  nbits_r, nbits_nxt;
  logic [63:0] offs_r, offs_nxt;
  logic [63:0] part_r, part_nxt;
  logic [5:0]  gath_r, gath_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [31:0] done_r, done_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r;
  logic        out_last_r, out_bad_r;

  logic        can_go;
  logic [3:0]  rem;
  logic [5:0]  need;
  logic        fits;
  logic [3:0]  take;
  logic [7:0]  cur;
  logic [7:0]  newbits;
  logic [63:0] joined;
  logic [63:0] sum;
  logic [31:0] done_inc;
  logic        is_last;
  logic [3:0]  pos_end;
  logic        emit;
  logic [63:0] emit_val;
  logic        emit_last, emit_bad;

  assign can_go   = !out_valid_r || out_ready;
  assign rem      = 4'd8 - {1'b0, pos_r};
  assign need     = nbits_r - gath_r;
  assign fits     = ({2'b00, rem} >= need);
  assign take     = fits ? need[3:0] : rem;
  assign cur      = q_entry.data[7:0] << pos_r;
  assign newbits  = cur >> (4'd8 - take);
  assign joined   = (part_r << take) | {56'd0, newbits};
  assign sum      = cfg_fill_defined ? joined : joined + offs_r;
  assign done_inc = done_r + 32'd1;
  assign is_last  = (done_inc == cfg_element_count);
  assign pos_end  = {1'b0, pos_r} + take;

  always_comb begin
    active_nxt = active_r;
    nbits_nxt  = nbits_r;
    offs_nxt   = offs_r;
    part_nxt   = part_r;
    gath_nxt   = gath_r;
    pos_nxt    = pos_r;
    done_nxt   = done_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_val   = sum & sou_pkg::width_mask(cfg_element_bytes);
    emit_last  = is_last;
    emit_bad   = 1'b0;
    if (q_valid && can_go) begin
      unique case (q_entry.cmd)
        sou_pkg::CMD_START: begin
          q_pop      = 1'b1;
          active_nxt = (cfg_element_count != 32'd0);
          nbits_nxt  = q_entry.nbits;
          offs_nxt   = q_entry.data;
          part_nxt   = 64'd0;
          gath_nxt   = 6'd0;
          done_nxt   = 32'd0;
        end
        sou_pkg::CMD_ERR: begin
          q_pop      = 1'b1;
          emit       = 1'b1;
          emit_val   = 64'd0;
          emit_last  = 1'b1;
          emit_bad   = 1'b1;
          active_nxt = 1'b0;
        end
        sou_pkg::CMD_DATA: begin
          if (!active_r) begin
            q_pop = 1'b1;
          end else if (!fits) begin
            part_nxt = joined;
            gath_nxt = gath_r + {2'b00, take};
            q_pop    = 1'b1;
          end else begin
            emit     = 1'b1;
            done_nxt = done_inc;
            part_nxt = 64'd0;
            gath_nxt = 6'd0;
            pos_nxt  = pos_end[2:0];
            if ((pos_end == 4'd8) || is_last) q_pop = 1'b1;
            if (is_last) active_nxt = 1'b0;
          end
        end
        default: begin
          q_pop = 1'b1;
        end
      endcase
      if (q_pop) begin
        pos_nxt = 3'd0;
        if (q_entry.last_byte) active_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      gath_r      <= 6'd0;
      pos_r       <= 3'd0;
      done_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      gath_r      <= gath_nxt;
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nbits_r <= nbits_nxt;
    offs_r  <= offs_nxt;
    part_r  <= part_nxt;
    if (emit) begin
      out_value_r <= emit_val;
      out_last_r  <= emit_last;
      out_bad_r   <= emit_bad;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_elem_value   = out_value_r;
  assign out_last_element = out_last_r;
  assign out_bad_header   = out_bad_r;

endmodule
`default_nettype wire

// ===== bench/scale_offset_unpacker_tb.sv =====
`timescale 1ns / 1ps
module scale_offset_unpacker_tb;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_DATA,
    ST_SKIP
  } parse_st_t;

  typedef enum int {
    PAT_RANDOM,
    PAT_ZERO,
    PAT_ONES
  } data_pat_t;

  typedef struct {
    logic [63:0] value;
    logic        last;
    logic        bad;
  } elem_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'd0;
  logic        in_chunk_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_elem_value;
  logic        out_last_element;
  logic        out_bad_header;
  logic        cfg_we = 1'b0;
  sou_pkg::reg_idx_t cfg_index = sou_pkg::REG_ELEMENT_COUNT;
  logic [31:0] cfg_data = 32'd0;

  // Mirror of the configuration registers.
  logic [31:0] cfg_count = 32'd1;
  logic [3:0]  cfg_bytes = 4'd4;
  logic        cfg_fill = 1'b0;
  logic [6:0]  cfg_req = 7'd0;

  // Decoder state as the block should hold it.
  parse_st_t   parse_st = ST_HEADER;
  logic [3:0]  hdr_pos = 4'd0;
  logic [31:0] hdr_bits = 32'd0;
  logic [63:0] hdr_min = 64'd0;
  logic [63:0] acc_bits = 64'd0;
  logic [6:0]  acc_count = 7'd0;
  logic [31:0] elems_done = 32'd0;

  elem_rec_t   pending_elems[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_fail = 0;
  int bytes_sent = 0;
  int chunks_sent = 0;
  int results_seen = 0;
  int cycle_cnt = 0;

  scale_offset_unpacker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_chunk_end     (in_chunk_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_elem_value   (out_elem_value),
    .out_last_element (out_last_element),
    .out_bad_header   (out_bad_header),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    elem_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_elems.size() == 0) begin
        $error("out_elem_value %h arrived with no result pending", out_elem_value);
        n_fail++;
      end else begin
        want = pending_elems.pop_front();
        if (out_elem_value !== want.value) begin
          $error("out_elem_value: expected %h, got %h", want.value, out_elem_value);
          n_fail++;
        end
        if (out_last_element !== want.last) begin
          $error("out_last_element: expected %b, got %b", want.last, out_last_element);
          n_fail++;
        end
        if (out_bad_header !== want.bad) begin
          $error("out_bad_header: expected %b, got %b", want.bad, out_bad_header);
          n_fail++;
        end
      end
    end
  end

  function automatic int unsigned clamp_width(input logic [3:0] eb);
    int unsigned nb;
    nb = eb;
    if (nb == 0) nb = 1;
    if (nb > 8) nb = 8;
    return nb * 8;
  endfunction

  function automatic void note_result(input logic [63:0] v, input logic l, input logic bd);
    elem_rec_t r;
    r.value = v;
    r.last  = l;
    r.bad   = bd;
    pending_elems.push_back(r);
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic e);
    int unsigned w;
    logic [63:0] mask;
    logic [63:0] v;
    int i;
    bit halted;
    w = clamp_width(cfg_bytes);
    mask = (w >= 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
    case (parse_st)
      ST_HEADER: begin
        if (hdr_pos == 4'd0) begin
          hdr_bits = 32'd0;
          hdr_min = 64'd0;
        end
        if (hdr_pos < 4'd4) begin
          hdr_bits = hdr_bits | (32'(b) << (8 * hdr_pos));
        end else if (hdr_pos < 4'd12) begin
          hdr_min = hdr_min | (64'(b) << (8 * (hdr_pos - 4'd4)));
        end
        hdr_pos = hdr_pos + 4'd1;
        if (hdr_pos >= 4'd12) begin
          hdr_pos = 4'd0;
          acc_bits = 64'd0;
          acc_count = 7'd0;
          elems_done = 32'd0;
          if (hdr_bits == 32'd0 || hdr_bits >= w || cfg_req > w) begin
            note_result(64'd0, 1'b1, 1'b1);
            parse_st = ST_SKIP;
          end else if (cfg_count == 32'd0) begin
            parse_st = ST_SKIP;
          end else begin
            parse_st = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        halted = 1'b0;
        for (i = 7; i >= 0; i--) begin
          if (!halted) begin
            acc_bits = {acc_bits[62:0], b[i]};
            acc_count = acc_count + 7'd1;
            if (acc_count >= hdr_bits) begin
              v = acc_bits;
              if (!cfg_fill) v = v + hdr_min;
              v = v & mask;
              elems_done = elems_done + 32'd1;
              note_result(v, elems_done == cfg_count, 1'b0);
              acc_bits = 64'd0;
              acc_count = 7'd0;
              if (elems_done == cfg_count) begin
                parse_st = ST_SKIP;
                halted = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (e) begin
      parse_st = ST_HEADER;
      hdr_pos = 4'd0;
      acc_bits = 64'd0;
      acc_count = 7'd0;
      elems_done = 32'd0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_chunk_end <= e;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, e);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] count, input logic [3:0] eb,
                            input logic fill, input logic [6:0] req);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= sou_pkg::REG_ELEMENT_COUNT;
    cfg_data <= count;
    @(posedge clk);
    cfg_index <= sou_pkg::REG_ELEMENT_BYTES;
    cfg_data <= {28'd0, eb};
    @(posedge clk);
    cfg_index <= sou_pkg::REG_FILL_DEFINED;
    cfg_data <= {31'd0, fill};
    @(posedge clk);
    cfg_index <= sou_pkg::REG_REQUESTED_BITS;
    cfg_data <= {25'd0, req};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_count = count;
    cfg_bytes = eb;
    cfg_fill = fill;
    cfg_req = req;
  endtask

  task automatic send_chunk_part(input logic [31:0] bits, input logic [63:0] minv,
                                 input int first, input int stop, input data_pat_t pat,
                                 input logic with_end);
    logic [7:0] b;
    int i;
    for (i = first; i < stop; i++) begin
      if (i < 4) begin
        b = bits[8*i +: 8];
      end else if (i < 12) begin
        b = minv[8*(i-4) +: 8];
      end else begin
        case (pat)
          PAT_ZERO: b = 8'h00;
          PAT_ONES: b = 8'hFF;
          default:  b = 8'($urandom);
        endcase
      end
      send_byte(b, with_end && (i == stop - 1));
    end
  endtask

  task automatic send_chunk(input logic [31:0] bits, input logic [63:0] minv,
                            input int len, input data_pat_t pat);
    send_chunk_part(bits, minv, 0, len, pat, 1'b1);
    chunks_sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_defaults();
    send_chunk(32'd13, 64'hFFFF_FFFF_FFFF_FFF0, 16, PAT_RANDOM);
    send_chunk(32'd31, 64'd0, 16, PAT_ONES);
  endtask

  task automatic test_header_errors();
    set_config(32'd4, 4'd4, 1'b0, 7'd0);
    send_chunk(32'd0, rand64(), 14, PAT_RANDOM);
    send_chunk(32'd32, rand64(), 14, PAT_RANDOM);
    send_chunk(32'hFFFF_FFFF, rand64(), 13, PAT_RANDOM);
    send_chunk(32'd9, rand64(), 7, PAT_RANDOM);
    set_config(32'd4, 4'd4, 1'b0, 7'd33);
    send_chunk(32'd9, rand64(), 17, PAT_RANDOM);
    set_config(32'd4, 4'd4, 1'b0, 7'd32);
    send_chunk(32'd9, rand64(), 17, PAT_RANDOM);
  endtask

  task automatic test_widths_and_fill();
    set_config(32'd3, 4'd8, 1'b0, 7'd64);
    send_chunk(32'd63, {64{1'b1}}, 36, PAT_ONES);
    set_config(32'd16, 4'd1, 1'b1, 7'd0);
    send_chunk(32'd1, 64'hA5, 14, PAT_RANDOM);
    set_config(32'd5, 4'd8, 1'b0, 7'd8);
    send_chunk(32'd8, rand64(), 17, PAT_RANDOM);
    set_config(32'd3, 4'd4, 1'b1, 7'd0);
    send_chunk(32'd16, rand64(), 18, PAT_ZERO);
    set_config(32'd4, 4'd0, 1'b0, 7'd8);
    send_chunk(32'd7, rand64(), 16, PAT_RANDOM);
    set_config(32'd3, 4'd12, 1'b0, 7'd127);
    send_chunk(32'd40, rand64(), 27, PAT_RANDOM);
    set_config(32'd3, 4'd15, 1'b0, 7'd64);
    send_chunk(32'd40, rand64(), 27, PAT_RANDOM);
  endtask

  task automatic test_count_extremes();
    set_config(32'd0, 4'd4, 1'b0, 7'd0);
    send_chunk(32'd5, rand64(), 15, PAT_RANDOM);
    set_config(32'hFFFF_FFFF, 4'd2, 1'b0, 7'd0);
    send_chunk(32'd15, rand64(), 18, PAT_RANDOM);
    set_config(32'd8, 4'd2, 1'b1, 7'd16);
    send_chunk(32'd10, rand64(), 16, PAT_RANDOM);
  endtask

  task automatic test_reconfig_mid_chunk();
    logic [63:0] minv;
    minv = rand64();
    set_config(32'd6, 4'd8, 1'b0, 7'd0);
    send_chunk_part(32'd12, minv, 0, 15, PAT_RANDOM, 1'b0);
    set_config(32'd6, 4'd2, 1'b1, 7'd0);
    send_chunk_part(32'd12, minv, 15, 21, PAT_RANDOM, 1'b1);
    chunks_sent++;
  endtask

  task automatic test_random_chunks(input int n_bytes);
    int stop_at;
    int unsigned w;
    logic [31:0] count;
    logic [3:0] eb;
    logic [6:0] req;
    logic [31:0] bits;
    int n_elem;
    int data_len;
    int len;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(19))
          0:       count = 32'd0;
          1:       count = 32'hFFFF_FFFF;
          default: count = $urandom_range(1, 10);
        endcase
        eb = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
        w = clamp_width(eb);
        req = ($urandom_range(7) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(0, w));
        set_config(count, eb, 1'($urandom), req);
      end
      w = clamp_width(cfg_bytes);
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0:       bits = 32'd0;
          1:       bits = w;
          default: bits = $urandom;
        endcase
      end else begin
        bits = $urandom_range(1, w - 1);
      end
      if (bits == 32'd0 || bits >= w) begin
        data_len = $urandom_range(0, 4);
      end else begin
        n_elem = (cfg_count == 32'd0) ? 2 :
                 (cfg_count > 32'd12) ? $urandom_range(1, 12) : int'(cfg_count);
        data_len = (n_elem * int'(bits) + 7) / 8;
      end
      len = 12 + data_len + $urandom_range(0, 2);
      if ($urandom_range(7) == 0) len = $urandom_range(1, len);
      send_chunk(bits, rand64(), len, PAT_RANDOM);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 46;
    test_reset_defaults();
    test_header_errors();
    test_widths_and_fill();
    test_count_extremes();
    test_reconfig_mid_chunk();
    test_random_chunks(35);

    send_idle_pct = 46;
    recv_idle_pct = 32;
    test_random_chunks(35);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_chunks(35);

    wait_drained();
    if (pending_elems.size() != 0) begin
      $error("%0d expected results never arrived", pending_elems.size());
      n_fail++;
    end
    $display("Sent %0d request bytes in %0d chunks and checked %0d results,",
             bytes_sent, chunks_sent, results_seen);
    $display("across header errors, all element widths, fill on and off and three stall mixes.");
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sou_pkg.sv
design/sou_front.sv
design/sou_fifo.sv
design/sou_back.sv
design/scale_offset_unpacker.sv
bench/scale_offset_unpacker_tb.sv
